### hdl/rgbps_pkg.sv
// Package: shared item types, register indexes, reset values and helpers for the LED pulse serializer.
`timescale 1ns / 1ps

package rgbps_pkg;

    // Input item as it arrives on the push side
    typedef struct packed {
        logic       kind;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
        logic       last_pixel;
    } in_item_t;

    // Result item as it leaves on the pop side
    typedef struct packed {
        logic pin_level;
        logic accepted;
        logic buffer_full;
        logic busy_res;
    } out_item_t;

    // Classified command between front and back
    typedef struct packed {
        logic        is_pixel;
        logic [23:0] pixel;
        logic        last;
    } cmd_t;

    // Item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PULSE_W    = 10;
    localparam int GAP_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_GAP = 3'd4;

    localparam logic [PULSE_W-1:0] ZERO_HIGH_RST = 10'd20;
    localparam logic [PULSE_W-1:0] ZERO_LOW_RST  = 10'd43;
    localparam logic [PULSE_W-1:0] ONE_HIGH_RST  = 10'd40;
    localparam logic [PULSE_W-1:0] ONE_LOW_RST   = 10'd23;
    localparam logic [GAP_W-1:0]   RESET_GAP_RST = 16'd3000;

    // Index of the last pixel bit; the bit counter counts down from it
    localparam logic [4:0] LAST_BIT_IDX = 5'd23;

    // Waveform phases, one-hot
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_LEAD  = 4'b0010,
        PH_BITS  = 4'b0100,
        PH_TRAIL = 4'b1000
    } phase_t;

    // Remaining cycles after the first one of a segment; a zero length acts as one
    function automatic logic [GAP_W-1:0] len_minus_one(input logic [GAP_W-1:0] len);
        len_minus_one = (len == '0) ? '0 : len - 16'd1;
    endfunction

endpackage

### hdl/rgbps_front.sv
// Front part: accepts items, classifies them into commands and queues them for the back part.
`timescale 1ns / 1ps

module rgbps_front
    import rgbps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    output logic     full,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;
    cmd_t       cmd_in;

    // Classify the item
    always_comb
    begin
        cmd_in.is_pixel = (item.kind == KIND_PIXEL);
        cmd_in.pixel    = {item.green, item.red, item.blue};
        cmd_in.last     = item.last_pixel;
    end

    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign do_pop    = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

`ifndef SYNTHESIS
    a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("command queue count did not grow on push");
    a_cnt_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("command queue count did not shrink on pop");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("command queue pointers disagree with count");
`endif

endmodule

### hdl/rgbps_back.sv
// Back part: runs the pin waveform engine and holding buffer, and queues result items.
`timescale 1ns / 1ps

module rgbps_back
    import rgbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  empty,
    input  logic                  pop,
    output out_item_t             result
);

    // Timing registers
    logic [PULSE_W-1:0] zero_high_reg, zero_low_reg, one_high_reg, one_low_reg;
    logic [GAP_W-1:0]   gap_reg;

    // Engine state
    phase_t      phase_reg, phase_next;
    logic [23:0] shifter_reg, shifter_next;
    logic [4:0]  bits_left_reg, bits_left_next;
    logic        high_reg, high_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        cur_last_reg, cur_last_next;
    logic [23:0] held_pixel_reg, held_pixel_next;
    logic        held_valid_reg, held_valid_next;
    logic        held_last_reg, held_last_next;

    // Result queue
    out_item_t   rq_reg [2];
    logic        rq_wr_reg, rq_rd_reg;
    logic [1:0]  rq_cnt_reg, rq_cnt_next;

    logic        exec, res_pop, res_space;
    logic        accepted;
    logic        load_req, trail_req;
    logic        new_bit;
    out_item_t   res_in;

    assign empty     = (rq_cnt_reg == 2'd0);
    assign res_pop   = pop && !empty;
    assign res_space = (rq_cnt_reg != 2'd2) || res_pop;
    assign exec      = cmd_valid && res_space;
    assign cmd_pop   = exec;
    assign result    = rq_reg[rq_rd_reg];
    assign new_bit   = shifter_reg[22];

    // Write timing registers; other indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_high_reg <= ZERO_HIGH_RST;
            zero_low_reg  <= ZERO_LOW_RST;
            one_high_reg  <= ONE_HIGH_RST;
            one_low_reg   <= ONE_LOW_RST;
            gap_reg       <= RESET_GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ZERO_HIGH: zero_high_reg <= cfg_data[PULSE_W-1:0];
                REG_ZERO_LOW:  zero_low_reg  <= cfg_data[PULSE_W-1:0];
                REG_ONE_HIGH:  one_high_reg  <= cfg_data[PULSE_W-1:0];
                REG_ONE_LOW:   one_low_reg   <= cfg_data[PULSE_W-1:0];
                REG_RESET_GAP: gap_reg       <= cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the waveform by one item
    always_comb
    begin
        phase_next      = phase_reg;
        shifter_next    = shifter_reg;
        bits_left_next  = bits_left_reg;
        high_next       = high_reg;
        cnt_next        = cnt_reg;
        cur_last_next   = cur_last_reg;
        held_pixel_next = held_pixel_reg;
        held_valid_next = held_valid_reg;
        held_last_next  = held_last_reg;
        accepted        = 1'b0;
        load_req        = 1'b0;
        trail_req       = 1'b0;

        if (exec)
        begin
            if (cmd.is_pixel)
            begin
                // Take the pixel only into an empty buffer
                if (!held_valid_reg)
                begin
                    held_pixel_next = cmd.pixel;
                    held_last_next  = cmd.last;
                    held_valid_next = 1'b1;
                    accepted        = 1'b1;
                end
            end
            else if (phase_reg == PH_IDLE)
            begin
                if (held_valid_reg)
                begin
                    phase_next = PH_LEAD;
                    high_next  = 1'b0;
                    cnt_next   = len_minus_one(gap_reg);
                end
            end
            else if (cnt_reg != 16'd0)
            begin
                cnt_next = cnt_reg - 16'd1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        load_req = 1'b1;
                    end
                    PH_TRAIL:
                    begin
                        phase_next = PH_IDLE;
                        high_next  = 1'b0;
                    end
                    PH_BITS:
                    begin
                        if (high_reg)
                        begin
                            high_next = 1'b0;
                            cnt_next  = len_minus_one({6'd0, shifter_reg[23] ?
                                                       one_low_reg : zero_low_reg});
                        end
                        else if (bits_left_reg != 5'd0)
                        begin
                            bits_left_next = bits_left_reg - 5'd1;
                            shifter_next   = {shifter_reg[22:0], 1'b0};
                            high_next      = 1'b1;
                            cnt_next       = len_minus_one({6'd0, new_bit ?
                                                            one_high_reg : zero_high_reg});
                        end
                        else if (cur_last_reg)
                        begin
                            trail_req = 1'b1;
                        end
                        else
                        begin
                            load_req = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            // Load the waiting pixel, or fall into the trailing gap on underrun or after the last pixel
            if (load_req)
            begin
                if (held_valid_reg)
                begin
                    shifter_next    = held_pixel_reg;
                    cur_last_next   = held_last_reg;
                    held_valid_next = 1'b0;
                    bits_left_next  = LAST_BIT_IDX;
                    phase_next      = PH_BITS;
                    high_next       = 1'b1;
                    cnt_next        = len_minus_one({6'd0, held_pixel_reg[23] ?
                                                     one_high_reg : zero_high_reg});
                end
                else
                begin
                    trail_req = 1'b1;
                end
            end

            if (trail_req)
            begin
                phase_next = PH_TRAIL;
                high_next  = 1'b0;
                cnt_next   = len_minus_one(gap_reg);
            end
        end
    end

    // Build the result from the updated state
    always_comb
    begin
        res_in.pin_level   = (phase_next == PH_BITS) && high_next;
        res_in.accepted    = accepted;
        res_in.buffer_full = held_valid_next;
        res_in.busy_res    = (phase_next != PH_IDLE);
    end

    always_comb
    begin
        rq_cnt_next = rq_cnt_reg + {1'b0, exec} - {1'b0, res_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            shifter_reg    <= 24'd0;
            bits_left_reg  <= 5'd0;
            high_reg       <= 1'b0;
            cnt_reg        <= 16'd0;
            cur_last_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            held_last_reg  <= 1'b0;
            rq_wr_reg      <= 1'b0;
            rq_rd_reg      <= 1'b0;
            rq_cnt_reg     <= 2'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            shifter_reg    <= shifter_next;
            bits_left_reg  <= bits_left_next;
            high_reg       <= high_next;
            cnt_reg        <= cnt_next;
            cur_last_reg   <= cur_last_next;
            held_valid_reg <= held_valid_next;
            held_last_reg  <= held_last_next;
            rq_wr_reg      <= exec ? !rq_wr_reg : rq_wr_reg;
            rq_rd_reg      <= res_pop ? !rq_rd_reg : rq_rd_reg;
            rq_cnt_reg     <= rq_cnt_next;
        end
    end

    // Hold the buffered pixel and queued results
    always_ff @(posedge clk)
    begin
        held_pixel_reg <= held_pixel_next;
        if (exec)
        begin
            rq_reg[rq_wr_reg] <= res_in;
        end
    end

`ifndef SYNTHESIS
    a_high_in_bits: assert property (@(posedge clk) disable iff (!rst_n)
        high_reg |-> (phase_reg == PH_BITS))
        else $error("pin high outside the bit phase");
    a_buf_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(held_valid_reg) |-> (phase_reg == PH_BITS && bits_left_reg == LAST_BIT_IDX))
        else $error("holding buffer emptied without loading a pixel");
    a_rq_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && !res_pop) |=> (rq_cnt_reg == $past(rq_cnt_reg) + 2'd1))
        else $error("result queue did not take the item");
    a_no_stall_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && rq_cnt_reg != 2'd2) |-> cmd_pop)
        else $error("engine stalled with room in result queue");
`endif

endmodule

### hdl/rgb_led_pulse_serializer_unit.sv
// Top level: LED pulse serializer with queue-style item and result sides.
`timescale 1ns / 1ps

// An accepted item passes through the command queue, then the result queue, to the result ports.
// Throughput: one item per cycle sustained while results are popped; the waveform engine updates once per item.
// Two-entry command and result queues let push and pop sides stall independently.
// Reset: rst_n clears all control state and loads the timing register defaults;
// no clearing pass, the block takes items in the first cycle after reset.
module rgb_led_pulse_serializer_unit
    import rgbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  in_item_t              item,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output out_item_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // Accept and classify items
    rgbps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Run the waveform and deliver results
    rgbps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### sim/tb.sv
// Testbench for the LED pulse serializer: directed table, random phases, waveform predictor.
`timescale 1ns / 1ps

module tb;
    import rgbps_pkg::*;

    // Cycles with no item moving before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // Receiver hold-off used to fill the block and stall its input
    localparam int LONG_HOLD = 120;
    localparam int DIR_ROWS = 20;

    // One directed row: the item, and an expected result where it is obvious
    typedef struct packed {
        logic      typed;
        out_item_t want;
        in_item_t  stim;
    } dir_row_t;

    // Directed items, run with short pulse and gap settings
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{1'b1, 4'b0000, '{KIND_TICK,  8'hFF, 8'hFF, 8'hFF, 1'b1}},  // idle tick, fields ignored
        '{1'b1, 4'b0110, '{KIND_PIXEL, 8'hFF, 8'h00, 8'hFF, 1'b0}},  // take pixel while idle
        '{1'b1, 4'b0010, '{KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 1'b1}},  // refuse: buffer full
        '{1'b1, 4'b0011, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0}},  // leading gap starts
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0}},
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0}},
        '{1'b0, 4'b0000, '{KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 1'b1}},  // offer while sending
        '{1'b0, 4'b0000, '{KIND_PIXEL, 8'hAA, 8'h55, 8'hA5, 1'b0}},  // refused again
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h5A, 8'hC3, 8'h0F, 1'b1}},
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0}},
        '{1'b0, 4'b0000, '{KIND_TICK,  8'hFF, 8'hFF, 8'hFF, 1'b0}},
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0}},
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0}},
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b1}},
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0}},
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0}},
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0}},
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0}},
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0}},
        '{1'b0, 4'b0000, '{KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0}}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    in_item_t              item = '0;
    logic                  full;
    logic                  empty;
    logic                  pop = 1'b0;
    out_item_t             result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Expected pin results, oldest first
    out_item_t pin_results_q [$];

    // Waveform predictor state
    phase_t      wave_ph = PH_IDLE;
    logic [23:0] shift_px = '0;
    logic [4:0]  bits_rem = '0;
    logic        high_half = 1'b0;
    logic [15:0] seg_left = '0;
    logic        frame_last = 1'b0;
    logic [23:0] buf_px = '0;
    logic        buf_ok = 1'b0;
    logic        buf_last = 1'b0;

    // Predictor copy of the timing registers
    logic [PULSE_W-1:0] zero_hi_len = ZERO_HIGH_RST;
    logic [PULSE_W-1:0] zero_lo_len = ZERO_LOW_RST;
    logic [PULSE_W-1:0] one_hi_len  = ONE_HIGH_RST;
    logic [PULSE_W-1:0] one_lo_len  = ONE_LOW_RST;
    logic [GAP_W-1:0]   gap_len     = RESET_GAP_RST;

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    bit long_hold_req = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;
    int idle_run = 0;

    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int pixels_taken = 0;
    int offers_refused = 0;
    int frames_done = 0;
    int underruns = 0;

    rgb_led_pulse_serializer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    // Cycles of a segment still to come after its first one; zero length acts as one
    function automatic logic [15:0] remaining_after(input logic [15:0] len);
        return (len == 16'd0) ? 16'd0 : len - 16'd1;
    endfunction

    function automatic void begin_high();
        high_half = 1'b1;
        seg_left = remaining_after({6'd0, shift_px[23] ? one_hi_len : zero_hi_len});
    endfunction

    function automatic void begin_gap(input phase_t ph);
        wave_ph = ph;
        high_half = 1'b0;
        seg_left = remaining_after(gap_len);
    endfunction

    // Load the waiting pixel, or close the frame when none is there
    function automatic void next_pixel_or_trail();
        if (buf_ok)
        begin
            shift_px = buf_px;
            frame_last = buf_last;
            buf_ok = 1'b0;
            bits_rem = LAST_BIT_IDX;
            wave_ph = PH_BITS;
            begin_high();
        end
        else
        begin
            begin_gap(PH_TRAIL);
        end
    endfunction

    // Advance the predictor by one item and return the pin result it causes
    function automatic void predict_pin(input in_item_t it, output out_item_t res);
        res = '0;
        if (it.kind == KIND_PIXEL)
        begin
            if (!buf_ok)
            begin
                buf_px = {it.green, it.red, it.blue};
                buf_last = it.last_pixel;
                buf_ok = 1'b1;
                res.accepted = 1'b1;
                pixels_taken++;
            end
            else
            begin
                offers_refused++;
            end
        end
        else if (wave_ph == PH_IDLE)
        begin
            if (buf_ok)
                begin_gap(PH_LEAD);
        end
        else if (seg_left != 16'd0)
        begin
            seg_left--;
        end
        else if (wave_ph == PH_LEAD)
        begin
            next_pixel_or_trail();
        end
        else if (wave_ph == PH_TRAIL)
        begin
            wave_ph = PH_IDLE;
            high_half = 1'b0;
        end
        else if (high_half)
        begin
            high_half = 1'b0;
            seg_left = remaining_after({6'd0, shift_px[23] ? one_lo_len : zero_lo_len});
        end
        else if (bits_rem != 5'd0)
        begin
            bits_rem--;
            shift_px = shift_px << 1;
            begin_high();
        end
        else if (frame_last)
        begin
            begin_gap(PH_TRAIL);
            frames_done++;
        end
        else
        begin
            if (!buf_ok)
                underruns++;
            next_pixel_or_trail();
        end
        res.pin_level = (wave_ph == PH_BITS) && high_half;
        res.buffer_full = buf_ok;
        res.busy_res = (wave_ph != PH_IDLE);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Write all timing registers plus one unused index; block must be drained
    task automatic program_timing(input logic [15:0] zh, input logic [15:0] zl,
                                  input logic [15:0] oh, input logic [15:0] ol,
                                  input logic [15:0] gap);
        logic [CFG_IDX_W-1:0] junk_idx;
        junk_idx = REG_RESET_GAP + CFG_IDX_W'($urandom_range(1, 3));
        write_reg(REG_ZERO_HIGH, zh);
        write_reg(REG_ZERO_LOW, zl);
        write_reg(REG_ONE_HIGH, oh);
        write_reg(REG_ONE_LOW, ol);
        write_reg(REG_RESET_GAP, gap);
        write_reg(junk_idx, 16'($urandom));
        cfg_we <= 1'b0;
        zero_hi_len = zh[PULSE_W-1:0];
        zero_lo_len = zl[PULSE_W-1:0];
        one_hi_len = oh[PULSE_W-1:0];
        one_lo_len = ol[PULSE_W-1:0];
        gap_len = gap;
    endtask

    // Offer one item until taken, record its expected result, then maybe idle
    task automatic offer_item(input in_item_t it, input logic typed, input out_item_t want);
        out_item_t pred;
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_pin(it, pred);
        pin_results_q.push_back(typed ? want : pred);
        items_sent++;
        if ($urandom_range(0, 99) < snd_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < snd_idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pin_results_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_color();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Random ticks and pixel offers; offer rate sets how often the buffer runs dry
    task automatic run_phase(input int n_items, input int offer_pct);
        in_item_t it;
        for (int k = 0; k < n_items; k++)
        begin
            it.kind = ($urandom_range(0, 99) < offer_pct) ? KIND_PIXEL : KIND_TICK;
            it.green = pick_color();
            it.red = pick_color();
            it.blue = pick_color();
            it.last_pixel = ($urandom_range(0, 3) == 0);
            offer_item(it, 1'b0, '0);
        end
        drain_results();
    endtask

    // Stimulus and configuration
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Zero high length acts as one; short gap
        program_timing(16'd0, 16'd1, 16'd2, 16'd1, 16'd2);
        for (int r = 0; r < DIR_ROWS; r++)
            offer_item(DIR_TAB[r].stim, DIR_TAB[r].typed, DIR_TAB[r].want);
        drain_results();

        // Zero gap acts as one; no idling
        program_timing(16'd1, 16'd2, 16'd1, 16'd1, 16'd0);
        run_phase(80, 25);

        snd_idle_pct = 46;
        program_timing(16'd2, 16'd1, 16'd1, 16'd2, 16'd3);
        run_phase(80, 15);

        // Shortest pulses, rare offers: pixels run out mid-frame
        snd_idle_pct = 0;
        rcv_stall_pct = 46;
        program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        run_phase(150, 2);

        // Upper bits of the pulse registers are dropped; long receiver hold
        snd_idle_pct = 38;
        rcv_stall_pct = 38;
        long_hold_req = 1'b1;
        program_timing(16'hFC01, 16'h0402, 16'd1, 16'd2, 16'd2);
        run_phase(80, 20);

        // Largest lengths last, since the gap never ends within the run
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        program_timing(16'd1023, 16'hFFFF, 16'd1023, 16'd1023, 16'hFFFF);
        run_phase(40, 30);

        repeat (10) @(posedge clk);
        $display("tb: %0d items, %0d results checked, %0d pixels taken, %0d offers refused",
                 items_sent, results_seen, pixels_taken, offers_refused);
        $display("tb: %0d frames ended by last flag, %0d underruns, %0d mismatches",
                 frames_done, underruns, mismatches);
        if (mismatches == 0 && pin_results_q.size() == 0)
            $display("[rgb_led_pulse_serializer_unit] OK");
        else
            $display("[rgb_led_pulse_serializer_unit] ERROR");
        $finish;
    end

    // Result side: check each popped item, then pick pop for the next cycle
    initial
    begin
        out_item_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                results_seen++;
                if (pin_results_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: unexpected result %b with nothing pending", result);
                end
                else
                begin
                    want = pin_results_q.pop_front();
                    if (result.pin_level !== want.pin_level ||
                        result.accepted !== want.accepted ||
                        result.buffer_full !== want.buffer_full ||
                        result.busy_res !== want.busy_res)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"tb: result %0d: expected pin %b acc %b full %b busy %b,",
                                      " got pin %b acc %b full %b busy %b"},
                                     results_seen, want.pin_level, want.accepted,
                                     want.buffer_full, want.busy_res, result.pin_level,
                                     result.accepted, result.buffer_full, result.busy_res);
                    end
                end
            end
            if (long_hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= rcv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("tb: no item moved for %0d cycles", STALL_LIMIT);
        $display("[rgb_led_pulse_serializer_unit] ERROR");
        $finish;
    end

endmodule
